[design/filled_circle_additive_blitter_unit_defines.svh]
// Shared assertion macros for the blitter. Both expect clk and rst in scope.
`ifndef FILLED_CIRCLE_ADDITIVE_BLITTER_UNIT_DEFINES_SVH
`define FILLED_CIRCLE_ADDITIVE_BLITTER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fcab_pkg.sv]
package fcab_pkg;

  localparam int SCREEN_W    = 256;
  localparam int SCREEN_H    = 256;
  localparam int BASE_RADIUS = 4;

  localparam int DEPTH  = SCREEN_W * SCREEN_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int X_W    = $clog2(SCREEN_W);
  localparam int Y_W    = $clog2(SCREEN_H);
  // largest drawable radius is BASE_RADIUS + 3
  localparam int RAD_W  = $clog2(BASE_RADIUS + 4);
  localparam int LIM_W  = 2 * RAD_W;
  localparam int BIT_W  = $clog2(RAD_W);
  localparam int DY_W   = RAD_W + 1;
  // signed screen coordinate: centre +/- radius, and screen edges up to 256
  localparam int CO_W   = 13;

  localparam logic [7:0] DOT_ALPHA = 8'd255;
  localparam logic [7:0] DOT_GREEN = 8'd125;
  localparam logic [7:0] DOT_BLUE  = 8'd125;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RWAIT,
    ST_ROW,
    ST_SQRT,
    ST_SPAN,
    ST_NEXT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [10:0] center_x;
    logic signed [10:0] center_y;
    logic [7:0]         dot_radius;
    logic [7:0]         read_x;
    logic [7:0]         read_y;
  } item_t;

  typedef struct packed {
    logic              load;
    logic [31:0]       pixel;
    logic              drawn;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // low byte of 510 * off, i.e. -2 * off
  function automatic logic [7:0] red_of(input logic [1:0] off);
    logic [7:0] t;
    t = {5'd0, off, 1'b0};
    return 8'd0 - t;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [31:0] blend_add(input logic [31:0] src, input logic [31:0] dst);
    return {8'hFF, sat_add(src[23:16], dst[23:16]), sat_add(src[15:8], dst[15:8]),
            sat_add(src[7:0], dst[7:0])};
  endfunction

endpackage

[design/filled_circle_additive_blitter_unit.sv]
// Filled-circle additive blitter. A frame store of 256x256 ARGB words sits in one
// single-port-write, one-read RAM with registered read data. Draw (command 1) walks
// rows dy = -r..r; per row it sets up in ST_ROW, runs the bit-serial square root that
// sets the half width in ST_SQRT, walks the clipped pixels one per cycle in ST_SPAN
// (read, then blend and write back in the following cycle), and steps the row in
// ST_NEXT. A row off screen goes from ST_ROW straight to ST_NEXT. A read (command 2)
// passes through ST_READ and ST_RWAIT to ST_FIN; a draw with an unsupported radius or
// command 3 goes straight to ST_FIN. Clear (command 0) writes one word per cycle; the
// same sweep runs after reset, with in_stall held high until it ends. A finished
// result sits in an output register, so the next command is taken while the previous
// result is still stalled.
module filled_circle_additive_blitter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [10:0] center_x,
  input  logic signed [10:0] center_y,
  input  logic [7:0]         dot_radius,
  input  logic [7:0]         read_x,
  input  logic [7:0]         read_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        pixel_value,
  output logic               dot_drawn
);

  fcab_pkg::item_t                item;
  fcab_pkg::res_t                 res;
  fcab_pkg::mem_req_t             mem_req;
  logic [31:0]                    rdata;
  logic                           sq_start;
  logic [fcab_pkg::LIM_W-1:0]     sq_lim;
  logic                           sq_done;
  logic [fcab_pkg::RAD_W-1:0]     sq_root;
  logic                           out_block;
  logic                           out_valid_next;

  assign item.command    = command;
  assign item.center_x   = center_x;
  assign item.center_y   = center_y;
  assign item.dot_radius = dot_radius;
  assign item.read_x     = read_x;
  assign item.read_y     = read_y;

  assign out_block = out_valid && out_stall;

  fcab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item      (item),
    .out_block (out_block),
    .res       (res),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .sq_start  (sq_start),
    .sq_lim    (sq_lim),
    .sq_done   (sq_done),
    .sq_root   (sq_root)
  );

  fcab_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .lim   (sq_lim),
    .done  (sq_done),
    .root  (sq_root)
  );

  fcab_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output beat register
  always_comb begin
    out_valid_next = out_valid;
    if (res.load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (res.load) begin
      pixel_value <= res.pixel;
      dot_drawn   <= res.drawn;
    end
  end

endmodule

[design/fcab_store.sv]
module fcab_store (
  input  logic               clk,
  input  fcab_pkg::mem_req_t req,
  output logic [31:0]        rdata
);

  logic [31:0] mem [fcab_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[design/fcab_sqrt.sv]
`include "filled_circle_additive_blitter_unit_defines.svh"

// floor(sqrt(lim)), one result bit per cycle, MSB first
module fcab_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fcab_pkg::LIM_W-1:0] lim,
  output logic                       done,
  output logic [fcab_pkg::RAD_W-1:0] root
);

  logic                       busy;
  logic [fcab_pkg::BIT_W-1:0] bit_idx;
  logic [fcab_pkg::LIM_W-1:0] lim_q;
  logic [fcab_pkg::RAD_W-1:0] trial;
  logic [fcab_pkg::LIM_W-1:0] trial_sq;

  assign trial    = root | (fcab_pkg::RAD_W'(1) << bit_idx);
  assign trial_sq = fcab_pkg::LIM_W'(trial) * fcab_pkg::LIM_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bit_idx == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bit_idx == '0)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      root    <= '0;
      lim_q   <= lim;
      bit_idx <= fcab_pkg::BIT_W'(fcab_pkg::RAD_W - 1);
    end else if (busy) begin
      if (trial_sq <= lim_q) begin
        root <= trial;
      end
      bit_idx <= bit_idx - fcab_pkg::BIT_W'(1);
    end
  end

  `FCAB_ASSERT_NOW(a_root_floor, done, (fcab_pkg::LIM_W'(root) * fcab_pkg::LIM_W'(root)) <= lim_q, "sqrt root too large")
  `FCAB_ASSERT_NOW(a_start_idle, start, !busy, "sqrt started while busy")

endmodule

[design/fcab_ctrl.sv]
`include "filled_circle_additive_blitter_unit_defines.svh"

module fcab_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fcab_pkg::item_t            item,
  input  logic                       out_block,
  output fcab_pkg::res_t             res,
  output fcab_pkg::mem_req_t         mem_req,
  input  logic [31:0]                rdata,
  output logic                       sq_start,
  output logic [fcab_pkg::LIM_W-1:0] sq_lim,
  input  logic                       sq_done,
  input  logic [fcab_pkg::RAD_W-1:0] sq_root
);

  localparam int CO_W = fcab_pkg::CO_W;
  localparam int ADDR_W = fcab_pkg::ADDR_W;
  localparam logic signed [CO_W-1:0] X_MAX = CO_W'(fcab_pkg::SCREEN_W - 1);
  localparam logic signed [CO_W-1:0] Y_LIM = CO_W'(fcab_pkg::SCREEN_H);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(fcab_pkg::DEPTH - 1);

  fcab_pkg::state_t state, state_next;

  logic [ADDR_W-1:0]               clr_addr;
  logic                            clr_report;
  logic signed [CO_W-1:0]          cx;
  logic signed [CO_W-1:0]          cy;
  logic [fcab_pkg::RAD_W-1:0]      rad;
  logic [fcab_pkg::LIM_W-1:0]      rsq;
  logic signed [fcab_pkg::DY_W-1:0] dy;
  logic signed [CO_W-1:0]          x;
  logic signed [CO_W-1:0]          x1;
  logic [ADDR_W-1:0]               row_base;
  logic                            pend;
  logic [ADDR_W-1:0]               pend_addr;
  logic [7:0]                      red;
  logic [31:0]                     res_pixel;
  logic                            res_drawn;

  logic                            acc;
  logic                            rad_ok;
  logic                            rd_ok;
  logic [fcab_pkg::RAD_W-1:0]      dy_mag;
  logic signed [CO_W-1:0]          y_sum;
  logic                            y_ok;
  logic signed [CO_W-1:0]          root_s;
  logic signed [CO_W-1:0]          x0_raw, x1_raw, x0c, x1c;
  logic                            span_empty;
  logic                            row_last;
  logic [ADDR_W-1:0]               pix_addr;
  logic [ADDR_W-1:0]               rd_addr_in;

  assign acc    = in_valid && !in_stall;
  assign rad_ok = (item.dot_radius >= 8'(fcab_pkg::BASE_RADIUS)) &&
                  (item.dot_radius <= 8'(fcab_pkg::BASE_RADIUS + 3));
  assign rd_ok  = ({4'd0, item.read_x} < 12'(fcab_pkg::SCREEN_W)) &&
                  ({4'd0, item.read_y} < 12'(fcab_pkg::SCREEN_H));
  assign rd_addr_in = ADDR_W'(item.read_y) * ADDR_W'(fcab_pkg::SCREEN_W) +
                      ADDR_W'(item.read_x);

  assign dy_mag = dy[fcab_pkg::DY_W-1] ? fcab_pkg::RAD_W'(-dy) : fcab_pkg::RAD_W'(dy);
  assign sq_lim = rsq - fcab_pkg::LIM_W'(dy_mag) * fcab_pkg::LIM_W'(dy_mag);
  assign y_sum  = cy + CO_W'(dy);
  assign y_ok   = (y_sum >= 0) && (y_sum < Y_LIM);
  assign row_last = (dy == $signed({1'b0, rad}));

  assign root_s     = CO_W'($signed({1'b0, sq_root}));
  assign x0_raw     = cx - root_s;
  assign x1_raw     = cx + root_s;
  assign x0c        = (x0_raw < 0) ? '0 : x0_raw;
  assign x1c        = (x1_raw > X_MAX) ? X_MAX : x1_raw;
  assign span_empty = x0c > x1c;

  assign pix_addr = row_base + ADDR_W'(x[fcab_pkg::X_W-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      fcab_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = clr_report ? fcab_pkg::ST_FIN : fcab_pkg::ST_IDLE;
        end
      end
      fcab_pkg::ST_IDLE: begin
        if (acc) begin
          case (item.command)
            fcab_pkg::CMD_CLEAR: state_next = fcab_pkg::ST_CLEAR;
            fcab_pkg::CMD_DRAW:  state_next = rad_ok ? fcab_pkg::ST_ROW : fcab_pkg::ST_FIN;
            fcab_pkg::CMD_READ:  state_next = rd_ok ? fcab_pkg::ST_READ : fcab_pkg::ST_FIN;
            default:             state_next = fcab_pkg::ST_FIN;
          endcase
        end
      end
      fcab_pkg::ST_READ:  state_next = fcab_pkg::ST_RWAIT;
      fcab_pkg::ST_RWAIT: state_next = fcab_pkg::ST_FIN;
      fcab_pkg::ST_ROW:   state_next = y_ok ? fcab_pkg::ST_SQRT : fcab_pkg::ST_NEXT;
      fcab_pkg::ST_SQRT: begin
        if (sq_done) begin
          state_next = span_empty ? fcab_pkg::ST_NEXT : fcab_pkg::ST_SPAN;
        end
      end
      fcab_pkg::ST_SPAN: begin
        if (x == x1) begin
          state_next = fcab_pkg::ST_NEXT;
        end
      end
      fcab_pkg::ST_NEXT: state_next = row_last ? fcab_pkg::ST_FIN : fcab_pkg::ST_ROW;
      fcab_pkg::ST_FIN: begin
        if (!out_block) begin
          state_next = fcab_pkg::ST_IDLE;
        end
      end
      default: state_next = fcab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != fcab_pkg::ST_IDLE);
    sq_start      = (state == fcab_pkg::ST_ROW) && y_ok;
    res.load      = (state == fcab_pkg::ST_FIN) && !out_block;
    res.pixel     = res_pixel;
    res.drawn     = res_drawn;
    mem_req.raddr = pix_addr;
    if (state == fcab_pkg::ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_addr;
      mem_req.wdata = '0;
    end else begin
      mem_req.we    = pend;
      mem_req.waddr = pend_addr;
      mem_req.wdata = fcab_pkg::blend_add(
                        {fcab_pkg::DOT_ALPHA, red, fcab_pkg::DOT_GREEN, fcab_pkg::DOT_BLUE},
                        rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcab_pkg::ST_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      pend       <= 1'b0;
    end else begin
      state <= state_next;
      // pixel read this cycle is blended and written back next cycle
      pend  <= (state == fcab_pkg::ST_SPAN);
      if (state == fcab_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (acc) begin
        clr_addr   <= '0;
        clr_report <= (item.command == fcab_pkg::CMD_CLEAR);
      end
    end

    pend_addr <= pix_addr;

    if (acc) begin
      cx        <= CO_W'(item.center_x);
      cy        <= CO_W'(item.center_y);
      rad       <= fcab_pkg::RAD_W'(item.dot_radius);
      rsq       <= fcab_pkg::LIM_W'(item.dot_radius) * fcab_pkg::LIM_W'(item.dot_radius);
      dy        <= -$signed({1'b0, fcab_pkg::RAD_W'(item.dot_radius)});
      red       <= fcab_pkg::red_of(2'(item.dot_radius - 8'(fcab_pkg::BASE_RADIUS)));
      res_pixel <= '0;
      res_drawn <= (item.command == fcab_pkg::CMD_DRAW) && rad_ok;
      row_base  <= rd_addr_in;
      x         <= '0;
    end

    case (state)
      fcab_pkg::ST_RWAIT: res_pixel <= rdata;
      fcab_pkg::ST_ROW: begin
        row_base <= ADDR_W'(y_sum[fcab_pkg::Y_W-1:0]) * ADDR_W'(fcab_pkg::SCREEN_W);
      end
      fcab_pkg::ST_SQRT: begin
        if (sq_done) begin
          x  <= x0c;
          x1 <= x1c;
        end
      end
      fcab_pkg::ST_SPAN: x <= x + CO_W'(1);
      fcab_pkg::ST_NEXT: dy <= dy + fcab_pkg::DY_W'(1);
      default: ;
    endcase
  end

  `FCAB_ASSERT_NOW(a_span_bound, state == fcab_pkg::ST_SPAN, x <= x1, "span walked past its end")
  `FCAB_ASSERT_NOW(a_rmw_apart, pend && (state == fcab_pkg::ST_SPAN), pend_addr != pix_addr, "read and write-back hit the same pixel")
  `FCAB_ASSERT_NEXT(a_drain, state == fcab_pkg::ST_NEXT, !pend, "write-back still pending after span")
  `FCAB_ASSERT_NOW(a_no_overrun, res.load, !out_block, "result loaded over a held beat")

endmodule
